// File: hw/rtl/waypoint_range_bearing_guide_macros.svh
// ---------------------------------------------------------------------------
// Waypoint range and bearing guide: assertion macros
// Shared assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef WAYPOINT_RANGE_BEARING_GUIDE_MACROS_SVH
`define WAYPOINT_RANGE_BEARING_GUIDE_MACROS_SVH

// Same-cycle implication, sampled on the clock, quiet during reset.
`define WRBG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("waypoint guide check failed");

// Next-cycle implication, sampled on the clock, quiet during reset.
`define WRBG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("waypoint guide check failed");

`endif

// File: hw/rtl/wrbg_pkg.sv
// ---------------------------------------------------------------------------
// Waypoint range and bearing guide package
// Shared constants, payload types, controller codes and the angle table.
// ---------------------------------------------------------------------------
package wrbg_pkg;

    localparam int WAYPOINT_DEPTH = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int PTR_W          = $clog2(WAYPOINT_DEPTH);
    localparam int CNT_W          = $clog2(WAYPOINT_DEPTH + 1);
    localparam int ITER_W         = 5;
    localparam int CFG_IDX_W      = 2;

    // Map offset of 300.0 in Q16.16.
    localparam logic signed [35:0] MAP_OFFSET = 36'sd19660800;

    localparam logic [CFG_IDX_W-1:0] CFG_LON_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_ORIGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LON_SCALE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_SCALE  = 2'd3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POSE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] waypoint_x;
        logic signed [31:0] waypoint_y;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic        [30:0] desired_range;
    } t_in_item;

    typedef struct packed {
        logic        [31:0] range;
        logic signed [15:0] bearing;
        logic               has_target;
        logic               waypoint_reached;
        logic               push_dropped;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_PUSH, S_NONE, S_MLON, S_MLAT, S_MDY, S_DIFF,
        S_SQX, S_SQY, S_SQADD, S_SQRT, S_LDA, S_NORMA, S_ROTA,
        S_LDB, S_NORMB, S_ROTB, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        t_state step;
        logic   accept;
        logic   out_load;
    } t_ctl;

    typedef struct packed {
        logic operation;
        logic empty;
        logic norm_done;
        logic rot_last;
        logic sqrt_last;
    } t_sts;

    // atan(2^-i) in 32-bit turns.
    function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/wrbg_in_if.sv
// ---------------------------------------------------------------------------
// Waypoint guide input channel
// Valid/ready channel carrying one push or pose item.
// ---------------------------------------------------------------------------
interface wrbg_in_if;
    logic              valid;
    logic              ready;
    wrbg_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/wrbg_out_if.sv
// ---------------------------------------------------------------------------
// Waypoint guide result channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface wrbg_out_if;
    logic               valid;
    logic               ready;
    wrbg_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/wrbg_ctrl.sv
// ---------------------------------------------------------------------------
// Waypoint guide controller
// Sequences the datapath through push, mapping, range and angle steps.
// ---------------------------------------------------------------------------
module wrbg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  wrbg_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output wrbg_pkg::t_ctl  o_ctl
);
    import wrbg_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.operation == OP_PUSH) n_state = S_PUSH;
                    else if (i_sts.empty)           n_state = S_NONE;
                    else                            n_state = S_MLON;
                end
            end
            S_PUSH:  n_state = S_OUT;
            S_NONE:  n_state = S_OUT;
            S_MLON:  n_state = S_MLAT;
            S_MLAT:  n_state = S_MDY;
            S_MDY:   n_state = S_DIFF;
            S_DIFF:  n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQADD;
            S_SQADD: n_state = S_SQRT;
            S_SQRT:  if (i_sts.sqrt_last) n_state = S_LDA;
            S_LDA:   n_state = S_NORMA;
            S_NORMA: if (i_sts.norm_done) n_state = S_ROTA;
            S_ROTA:  if (i_sts.rot_last) n_state = S_LDB;
            S_LDB:   n_state = S_NORMB;
            S_NORMB: if (i_sts.norm_done) n_state = S_ROTB;
            S_ROTB:  if (i_sts.rot_last) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        out_load     = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
        o_ctl.step     = r_state;
        o_ctl.accept   = (r_state == S_IDLE) && i_in_valid;
        o_ctl.out_load = out_load;
        n_out_valid  = out_load ? 1'b1 : (r_out_valid && !i_out_ready);
        o_out_valid  = r_out_valid;
    end

endmodule

// File: hw/rtl/wrbg_dp.sv
// ---------------------------------------------------------------------------
// Waypoint guide datapath
// Waypoint queue, configuration, shared multiplier, square root and CORDIC.
// ---------------------------------------------------------------------------
module wrbg_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wrbg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  wrbg_pkg::t_in_item                 i_item,
    input  wrbg_pkg::t_ctl                     i_ctl,
    output wrbg_pkg::t_sts                     o_sts,
    output wrbg_pkg::t_out_item                o_result
);
    import wrbg_pkg::*;

    function automatic logic signed [31:0] map_fix(input logic [63:0] p, input logic neg);
        logic [40:0]        m;
        logic [33:0]        mc;
        logic signed [35:0] v;
        m  = p[63:23];
        mc = (m > 41'h2_0000_0000) ? 34'h2_0000_0000 : m[33:0];
        v  = neg ? -$signed({2'b00, mc}) : $signed({2'b00, mc});
        v  = v - MAP_OFFSET;
        if (v > 36'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000) return 32'sh8000_0000;
        else                            return v[31:0];
    endfunction

    localparam logic signed [44:0] LIM40 = 45'sh100_0000_0000;
    localparam logic signed [44:0] LIM32 = 45'sh1_0000_0000;

    // Configuration.
    logic signed [31:0] r_lon_org, r_lat_org;
    logic [31:0]        r_lon_scl, r_lat_scl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lon_org <= '0;
            r_lat_org <= '0;
            r_lon_scl <= 32'h0001_0000;
            r_lat_scl <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LON_ORIGIN: r_lon_org <= i_cfg_data;
                CFG_LAT_ORIGIN: r_lat_org <= i_cfg_data;
                CFG_LON_SCALE:  r_lon_scl <= i_cfg_data;
                CFG_LAT_SCALE:  r_lat_scl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latched item.
    t_in_item r_in;
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) r_in <= i_item;
    end

    // Waypoint queue.
    logic [63:0]      r_mem [WAYPOINT_DEPTH];
    logic [63:0]      r_rd;
    logic [PTR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_count;
    logic             full, empty, do_push, do_pop;

    assign full    = (r_count == CNT_W'(WAYPOINT_DEPTH));
    assign empty   = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_tail] <= {r_in.waypoint_x, r_in.waypoint_y};
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (r_tail == PTR_W'(WAYPOINT_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= (r_head == PTR_W'(WAYPOINT_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (do_push)     r_count <= r_count + 1'b1;
            else if (do_pop) r_count <= r_count - 1'b1;
        end
    end

    // Mapping, distance and yaw terms.
    logic signed [32:0] d_lon, d_lat, ax33;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        r_prod, r_sum;
    logic signed [31:0] r_bx, r_by, r_s, r_c;
    logic signed [32:0] r_dx, r_dy;
    logic               r_sat;
    logic [63:0]        r_n, r_root, r_bit, sq_try;
    logic [64:0]        sq_total;

    assign d_lon    = {r_in.longitude[31], r_in.longitude} - {r_lon_org[31], r_lon_org};
    assign d_lat    = {r_in.latitude[31], r_in.latitude} - {r_lat_org[31], r_lat_org};
    assign sq_total = {1'b0, r_sum} + {1'b0, r_prod};
    assign sq_try   = r_root + r_bit;

    always_comb begin
        ax33 = '0;
        case (i_ctl.step)
            S_MLON: begin
                ax33  = d_lon[32] ? -d_lon : d_lon;
                mul_b = r_lon_scl;
            end
            S_MLAT: begin
                ax33  = d_lat[32] ? -d_lat : d_lat;
                mul_b = r_lat_scl;
            end
            S_SQX: begin
                ax33  = r_dx[32] ? -r_dx : r_dx;
                mul_b = ax33[31:0];
            end
            default: begin
                ax33  = r_dy[32] ? -r_dy : r_dy;
                mul_b = ax33[31:0];
            end
        endcase
        mul_a = ax33[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_ctl.step)
            S_MLAT: r_bx <= map_fix(r_prod, d_lon[32]);
            S_MDY: begin
                r_by <= map_fix(r_prod, d_lat[32]);
                r_dx <= {r_rd[63], r_rd[63:32]} - {r_bx[31], r_bx};
                r_s  <= 32'(2 * (32'(r_in.quat_w * r_in.quat_z) +
                                 32'(r_in.quat_x * r_in.quat_y)));
            end
            S_DIFF: begin
                r_dy <= {r_rd[31], r_rd[31:0]} - {r_by[31], r_by};
                r_c  <= 32'sh1000_0000 - 32'(2 * (32'(r_in.quat_y * r_in.quat_y) +
                                                  32'(r_in.quat_z * r_in.quat_z)));
            end
            S_SQX: r_sat <= (r_dx > 33'sh0_FFFF_FFFF) || (r_dx < -33'sh0_FFFF_FFFF) ||
                            (r_dy > 33'sh0_FFFF_FFFF) || (r_dy < -33'sh0_FFFF_FFFF);
            S_SQY: r_sum <= r_prod;
            S_SQADD: begin
                if (sq_total[64]) r_sat <= 1'b1;
                r_n    <= sq_total[63:0];
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end
            S_SQRT: begin
                if (r_n >= sq_try) begin
                    r_n    <= r_n - sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: ;
        endcase
    end

    // Shared vectoring CORDIC.
    logic signed [44:0] r_cx, r_cy, ld_x, ld_y, cx_s, cy_s;
    logic [31:0]        r_cz, r_z1, ld_z, z_out;
    logic               r_czero, r_zero1, ld_zero, low_mag;
    logic [ITER_W-1:0]  r_iter;
    logic               norm_done;

    always_comb begin
        logic signed [44:0] x0, y0;
        if (i_ctl.step == S_LDA) begin
            x0 = 45'(r_dx);
            y0 = 45'(r_dy);
        end else begin
            x0 = 45'(r_c);
            y0 = 45'(r_s);
        end
        ld_zero = (x0 == '0) && (y0 == '0);
        ld_x = x0;
        ld_y = y0;
        ld_z = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                ld_x = y0;
                ld_y = -x0;
                ld_z = 32'h4000_0000;
            end else begin
                ld_x = -y0;
                ld_y = x0;
                ld_z = 32'hC000_0000;
            end
        end
    end

    assign norm_done = r_czero || !((r_cx < LIM40) && (r_cx > -LIM40) &&
                                    (r_cy < LIM40) && (r_cy > -LIM40));
    assign low_mag   = (r_cx < LIM32) && (r_cx > -LIM32) && (r_cy < LIM32) && (r_cy > -LIM32);
    assign cx_s      = r_cx >>> r_iter;
    assign cy_s      = r_cy >>> r_iter;
    assign z_out     = r_czero ? 32'h0 : r_cz;

    always_ff @(posedge i_clk) begin
        case (i_ctl.step)
            S_LDA, S_LDB: begin
                r_cx    <= ld_x;
                r_cy    <= ld_y;
                r_cz    <= ld_z;
                r_czero <= ld_zero;
                r_iter  <= '0;
                if (i_ctl.step == S_LDB) begin
                    r_z1    <= z_out;
                    r_zero1 <= r_czero;
                end
            end
            S_NORMA, S_NORMB: begin
                if (!norm_done) begin
                    r_cx <= low_mag ? (r_cx <<< 8) : (r_cx <<< 1);
                    r_cy <= low_mag ? (r_cy <<< 8) : (r_cy <<< 1);
                end
            end
            S_ROTA, S_ROTB: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + cy_s;
                    r_cy <= r_cy - cx_s;
                    r_cz <= r_cz + atan_turn(r_iter);
                end else begin
                    r_cx <= r_cx - cy_s;
                    r_cy <= r_cy + cx_s;
                    r_cz <= r_cz - atan_turn(r_iter);
                end
                r_iter <= r_iter + 1'b1;
            end
            default: ;
        endcase
    end

    // Result assembly.
    t_out_item r_res, r_obuf;
    logic [31:0] range_v, diff;
    logic        reached;

    assign range_v = r_sat ? 32'hFFFF_FFFF : r_root[31:0];
    assign diff    = r_z1 - z_out + 32'h0000_8000;
    assign reached = (range_v < {1'b0, r_in.desired_range});
    assign do_push = (i_ctl.step == S_PUSH) && !full;
    assign do_pop  = (i_ctl.step == S_FIN) && reached;

    always_ff @(posedge i_clk) begin
        case (i_ctl.step)
            S_PUSH: begin
                r_res <= '{range: '0, bearing: '0, has_target: 1'b0,
                           waypoint_reached: 1'b0, push_dropped: full};
            end
            S_NONE: r_res <= '0;
            S_FIN: begin
                r_res.range            <= range_v;
                r_res.bearing          <= r_zero1 ? 16'sh0 : diff[31:16];
                r_res.has_target       <= 1'b1;
                r_res.waypoint_reached <= reached;
                r_res.push_dropped     <= 1'b0;
            end
            default: ;
        endcase
        if (i_ctl.out_load) r_obuf <= r_res;
    end

    assign o_result       = r_obuf;
    assign o_sts.operation = i_item.operation;
    assign o_sts.empty     = empty;
    assign o_sts.norm_done = norm_done;
    assign o_sts.rot_last  = (r_iter == ITER_W'(CORDIC_STEPS - 1));
    assign o_sts.sqrt_last = r_bit[0];

endmodule

// File: hw/rtl/waypoint_range_bearing_guide.sv
// ---------------------------------------------------------------------------
// Waypoint range and bearing guide
// Waypoint queue with range and bearing to the head waypoint per pose.
// ---------------------------------------------------------------------------
// Usage: items enter on i_item, a valid/ready channel. A push item appends
// a waypoint to a 16-entry queue, or flags push_dropped when the queue is
// full. A pose item maps latitude and longitude to map coordinates and
// returns range and bearing to the head waypoint, popping it when the
// range is below the desired range. Every transaction gives one result on
// o_result. Configuration registers are written through i_cfg_we, i_cfg_index
// and i_cfg_data; the user must do so only while the block is idle, as the
// block itself does not enforce it. A push, or a pose that finds the queue
// empty, fills the result register in S_PUSH or S_NONE and is loaded into
// the output register in S_OUT; the next item is taken back in S_IDLE. A pose
// with a target runs a square root loop and two CORDIC runs of 16 rotations,
// each after a normalizing pass. One item is in work at a time.
// Reset clears the queue, the controller and both origins, and sets both scales to 0x10000.
// A stalled receiver holds the result in the output register; the next
// item is still accepted and worked on, and waits only at its own end.
// ---------------------------------------------------------------------------
module waypoint_range_bearing_guide (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wrbg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    wrbg_in_if.sink                        i_item,
    wrbg_out_if.source                     o_result
);
    import wrbg_pkg::*;

    // Controller and datapath talk only through these two bundles.
    t_ctl ctl;
    t_sts sts;

    wrbg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_ctl       (ctl)
    );

    // The datapath holds the queue, the configuration and the result.
    wrbg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item.payload),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_result    (o_result.payload)
    );

endmodule

// File: hw/rtl/wrbg_checker.sv
// ---------------------------------------------------------------------------
// Waypoint guide checker
// Port-level checks on result consistency and acceptance.
// ---------------------------------------------------------------------------
`include "waypoint_range_bearing_guide_macros.svh"

module wrbg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic [31:0] i_out_range,
    input logic [15:0] i_out_bearing,
    input logic        i_out_has,
    input logic        i_out_reached,
    input logic        i_out_dropped
);

    `WRBG_ASSERT_IMP(a_drop_no_target, i_out_valid && i_out_dropped, !i_out_has && !i_out_reached)
    `WRBG_ASSERT_IMP(a_reached_has, i_out_valid && i_out_reached, i_out_has)
    `WRBG_ASSERT_IMP(a_no_target_zero, i_out_valid && !i_out_has,
                     i_out_range == 32'h0 && i_out_bearing == 16'h0)
    `WRBG_ASSERT_NXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind waypoint_range_bearing_guide wrbg_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_range   (o_result.payload.range),
    .i_out_bearing (o_result.payload.bearing),
    .i_out_has     (o_result.payload.has_target),
    .i_out_reached (o_result.payload.waypoint_reached),
    .i_out_dropped (o_result.payload.push_dropped)
);
